@@ hdl/irt_pkg.sv @@
// Shared types and constants for the inode reference count table.
// Holds table geometry, the sector divider constants, codes and the result record.
// Used by irt_engine and the top level; depends on nothing.
`default_nettype none

package irt_pkg;

    localparam int TABLE_SLOTS       = 128;
    localparam int INODES_PER_SECTOR = 8;

    localparam int SLOT_W   = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CNT_W    = SLOT_W + 1;
    localparam int INODE_W  = 16;
    localparam int REFS_W   = 16;
    localparam int RSLOT_W  = 7;
    localparam int SECTOR_W = 16;
    localparam int ENTRY_W  = INODE_W + REFS_W;

    // Division by the sector packing factor as a multiply by a rounded-up
    // reciprocal; the shift covers every divisor up to 64 exactly.
    localparam int DIV_SHIFT  = INODE_W + 6;
    localparam int DIV_MULT_W = DIV_SHIFT + 1;
    localparam int PROD_W     = INODE_W + DIV_MULT_W;
    localparam logic [DIV_MULT_W-1:0] DIV_MULT =
        DIV_MULT_W'((2**DIV_SHIFT + INODES_PER_SECTOR - 1) / INODES_PER_SECTOR);

    localparam logic [REFS_W-1:0] REFS_MAX = '1;
    localparam logic [REFS_W-1:0] REFS_ONE = REFS_W'(1);

    typedef enum logic [0:0] {
        CMD_GET = 1'b0,
        CMD_PUT = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_IDLE_PUT = 2'd2
    } t_status;

    typedef struct packed {
        logic [RSLOT_W-1:0]  result_slot;
        logic                hit;
        logic                read_needed;
        logic [SECTOR_W-1:0] read_sector;
        t_status             status;
        logic                released;
        logic [INODE_W-1:0]  released_inode;
    } t_result;

endpackage

`default_nettype wire

@@ hdl/irt_ram.sv @@
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered. No dependencies.
`default_nettype none

module irt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_we,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                 i_wdata,
    input  wire logic                             i_re,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ hdl/irt_engine.sv @@
// Lookup and update sequencer for the inode reference count table.
// Scans the slot RAM for gets, then writes the hit or free slot it found;
// puts read, modify and write back one slot. Depends on irt_pkg and irt_ram.
`default_nettype none

module irt_engine (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_item_valid,
    output logic                                 o_item_stall,
    input  wire logic                            i_cmd,
    input  wire logic [irt_pkg::INODE_W-1:0]     i_inode_number,
    input  wire logic [irt_pkg::RSLOT_W-1:0]     i_slot,
    input  wire logic [irt_pkg::SECTOR_W-1:0]    i_start_sector,
    output logic                                 o_res_valid,
    input  wire logic                            i_res_take,
    output irt_pkg::t_result                     o_res
);
    import irt_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_GDONE = 5'b00100,
        S_PREAD = 5'b01000,
        S_PDONE = 5'b10000
    } t_state;

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [INODE_W-1:0]  r_inum, n_inum;
    logic                r_rd_vld;
    logic [SLOT_W-1:0]   r_rd_idx;
    logic                r_found, n_found;
    logic [SLOT_W-1:0]   r_match, n_match;
    logic [REFS_W-1:0]   r_match_refs, n_match_refs;
    logic [INODE_W-1:0]  r_match_inode, n_match_inode;
    logic                r_have_free, n_have_free;
    logic [SLOT_W-1:0]   r_free, n_free;
    logic [INODE_W-1:0]  r_quot;
    logic [TABLE_SLOTS-1:0] r_live;

    logic                accept;
    logic                slot_in_range;
    logic                ram_re;
    logic [SLOT_W-1:0]   ram_raddr;
    logic                ram_we;
    logic [SLOT_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic [ENTRY_W-1:0]  ram_rdata;
    logic [INODE_W-1:0]  rd_inode;
    logic [REFS_W-1:0]   rd_refs;
    logic [PROD_W-1:0]   quot_prod;
    logic [REFS_W-1:0]   inc_refs;
    logic                handoff;

    irt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_item_stall  = (r_state != S_IDLE);
    assign accept        = (r_state == S_IDLE) && i_item_valid;
    assign slot_in_range = (32'(i_slot) < 32'(TABLE_SLOTS));

    // An entry never written since reset reads as a free slot.
    assign rd_inode = ram_rdata[ENTRY_W-1:REFS_W];
    assign rd_refs  = r_live[r_rd_idx] ? ram_rdata[REFS_W-1:0] : '0;

    assign quot_prod = PROD_W'(r_inum) * PROD_W'(DIV_MULT);
    assign inc_refs  = (r_match_refs == REFS_MAX) ? r_match_refs : r_match_refs + REFS_ONE;

    assign o_res_valid = (r_state == S_GDONE) || (r_state == S_PDONE);
    assign handoff     = o_res_valid && i_res_take;

    always_comb begin
        ram_re    = 1'b0;
        ram_raddr = '0;
        if (accept && (i_cmd == CMD_PUT) && slot_in_range) begin
            ram_re    = 1'b1;
            ram_raddr = SLOT_W'(i_slot);
        end else if (r_state == S_SCAN && r_cnt < CNT_W'(TABLE_SLOTS)) begin
            ram_re    = 1'b1;
            ram_raddr = r_cnt[SLOT_W-1:0];
        end
    end

    always_comb begin
        o_res       = '0;
        o_res.status = ST_OK;
        ram_we      = 1'b0;
        ram_waddr   = r_match;
        ram_wdata   = {r_match_inode, r_match_refs};
        case (r_state)
            S_GDONE: begin
                if (r_found) begin
                    o_res.result_slot = RSLOT_W'(r_match);
                    o_res.hit         = 1'b1;
                    ram_we            = handoff;
                    ram_waddr         = r_match;
                    ram_wdata         = {r_inum, inc_refs};
                end else if (r_have_free) begin
                    o_res.result_slot = RSLOT_W'(r_free);
                    o_res.read_needed = 1'b1;
                    o_res.read_sector = i_start_sector + r_quot;
                    ram_we            = handoff;
                    ram_waddr         = r_free;
                    ram_wdata         = {r_inum, REFS_ONE};
                end else begin
                    o_res.status = ST_FULL;
                end
            end
            S_PDONE: begin
                if (r_match_refs == '0) begin
                    o_res.status = ST_IDLE_PUT;
                end else begin
                    o_res.released       = (r_match_refs == REFS_ONE);
                    o_res.released_inode = (r_match_refs == REFS_ONE) ? r_match_inode : '0;
                    ram_we               = handoff;
                    ram_waddr            = r_match;
                    ram_wdata            = {r_match_inode, r_match_refs - REFS_ONE};
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state       = r_state;
        n_cnt         = r_cnt;
        n_inum        = r_inum;
        n_found       = r_found;
        n_match       = r_match;
        n_match_refs  = r_match_refs;
        n_match_inode = r_match_inode;
        n_have_free   = r_have_free;
        n_free        = r_free;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_inum      = i_inode_number;
                    n_found     = 1'b0;
                    n_have_free = 1'b0;
                    n_cnt       = '0;
                    n_match     = SLOT_W'(i_slot);
                    if (i_cmd == CMD_GET) begin
                        n_state = S_SCAN;
                    end else if (slot_in_range) begin
                        n_state = S_PREAD;
                    end else begin
                        n_match_refs = '0;
                        n_state      = S_PDONE;
                    end
                end
            end
            S_SCAN: begin
                if (r_cnt < CNT_W'(TABLE_SLOTS)) begin
                    n_cnt = r_cnt + CNT_W'(1);
                end else begin
                    n_state = S_GDONE;
                end
                if (r_rd_vld) begin
                    if (!r_found && rd_refs != '0 && rd_inode == r_inum) begin
                        n_found      = 1'b1;
                        n_match      = r_rd_idx;
                        n_match_refs = rd_refs;
                    end
                    if (!r_have_free && rd_refs == '0) begin
                        n_have_free = 1'b1;
                        n_free      = r_rd_idx;
                    end
                end
            end
            S_PREAD: begin
                n_match_refs  = rd_refs;
                n_match_inode = rd_inode;
                n_state       = S_PDONE;
            end
            S_GDONE, S_PDONE: begin
                if (handoff) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rd_vld <= 1'b0;
            r_live   <= '0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= ram_re;
            if (ram_we) begin
                r_live[ram_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt         <= n_cnt;
        r_inum        <= n_inum;
        r_rd_idx      <= ram_raddr;
        r_found       <= n_found;
        r_match       <= n_match;
        r_match_refs  <= n_match_refs;
        r_match_inode <= n_match_inode;
        r_have_free   <= n_have_free;
        r_free        <= n_free;
        r_quot        <= quot_prod[DIV_SHIFT +: INODE_W];
    end

endmodule

`default_nettype wire

@@ hdl/inode_refcount_table.sv @@
// Top level of the inode reference count table.
// Holds the start sector register and the result register; depends on irt_pkg and irt_engine.
//
// Usage:
// Requests arrive on the input channel (i_in_valid, o_in_stall) with i_cmd,
// i_inode_number and i_slot. A transfer happens at a clock edge with valid high
// and stall low. Every request gives exactly one result on the output channel
// (o_out_valid, i_out_stall). A get walks all TABLE_SLOTS entries of the slot RAM,
// one read per cycle, before its result is produced. A put reads, modifies
// and writes back one entry. Items are handled one at a time; the write-back
// ends before the next lookup. The result register lets the sequencer take a
// new request while a result waits; when the receiver stalls the result is held
// and the sequencer stops once its next result is ready. The start sector
// register is written through i_cfg_valid/o_cfg_ready/i_cfg_data; the user must
// write it only while no request is in flight. The block does not enforce this.
// Synchronous reset clears the start sector register to zero and marks every slot free.
`default_nettype none

module inode_refcount_table (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic                            i_cmd,
    input  wire logic [irt_pkg::INODE_W-1:0]     i_inode_number,
    input  wire logic [irt_pkg::RSLOT_W-1:0]     i_slot,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic      [irt_pkg::RSLOT_W-1:0]     o_result_slot,
    output logic                                 o_hit,
    output logic                                 o_read_needed,
    output logic      [irt_pkg::SECTOR_W-1:0]    o_read_sector,
    output logic      [1:0]                      o_status,
    output logic                                 o_released,
    output logic      [irt_pkg::INODE_W-1:0]     o_released_inode,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [irt_pkg::SECTOR_W-1:0]    i_cfg_data
);
    import irt_pkg::*;

    logic [SECTOR_W-1:0] r_start_sector;
    logic                r_out_valid;
    t_result             r_out;
    logic                res_valid;
    logic                res_take;
    t_result             res;

    assign o_cfg_ready = 1'b1;
    assign res_take    = !r_out_valid || !i_out_stall;

    irt_engine u_engine (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item_valid   (i_in_valid),
        .o_item_stall   (o_in_stall),
        .i_cmd          (i_cmd),
        .i_inode_number (i_inode_number),
        .i_slot         (i_slot),
        .i_start_sector (r_start_sector),
        .o_res_valid    (res_valid),
        .i_res_take     (res_take),
        .o_res          (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_sector <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_start_sector <= i_cfg_data;
            end
            if (res_take) begin
                r_out_valid <= res_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_result_slot    = r_out.result_slot;
    assign o_hit            = r_out.hit;
    assign o_read_needed    = r_out.read_needed;
    assign o_read_sector    = r_out.read_sector;
    assign o_status         = r_out.status;
    assign o_released       = r_out.released;
    assign o_released_inode = r_out.released_inode;

    // The sequencer takes no request while it is working on one.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request taken while the previous one is still in work");

    a_busy_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> o_in_stall)
        else $error("pending result while the input side is open");

    a_out_from_engine: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(res_valid))
        else $error("result register loaded without a result");

    a_error_fields_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_valid && res.status != ST_OK) |->
            (!res.hit && !res.read_needed && !res.released))
        else $error("error result carries success flags");

endmodule

`default_nettype wire
